// ----- hw/rtl/qrro_pkg.sv -----
`timescale 1ns / 1ps

package qrro_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int DISC_W  = 2 * WORD_BITS + 1;
   localparam int ROOT_W  = WORD_BITS + 1;
   localparam int NUM_W   = ROOT_W + 2;
   localparam int MAG_W   = ROOT_W + 1;
   localparam int NUMER_W = MAG_W + FRAC_BITS;
   localparam int DEN_W   = WORD_BITS + 1;

   localparam logic [WORD_BITS-1:0] MINUS_ONE =
      (FRAC_BITS >= WORD_BITS - 1) ? (WORD_BITS'(1) << (WORD_BITS - 1))
                                   : (WORD_BITS'(0) - (WORD_BITS'(1) << FRAC_BITS));

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_REAL   = 2'd1,
      ST_ZERO_LEAD = 2'd2,
      ST_SAT       = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] coef_sq;
      logic signed [WORD_BITS-1:0] coef_lin;
      logic signed [WORD_BITS-1:0] coef_const;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] low_root;
      logic signed [WORD_BITS-1:0] high_root;
      status_type                  status;
   } rsp_type;

   typedef struct packed {
      logic                 a_neg;
      logic [WORD_BITS-1:0] a_mag;
      logic [WORD_BITS-1:0] b;
      status_type           code;
   } sqrt_side_type;

   typedef struct packed {
      logic       lo_neg;
      logic       hi_neg;
      status_type code;
   } div_side_type;

endpackage

// ----- hw/rtl/qrro_sqrt.sv -----
`timescale 1ns / 1ps

module qrro_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [qrro_pkg::DISC_W-1:0] rad,
   output logic [qrro_pkg::ROOT_W-1:0] root
);

   localparam int SW = qrro_pkg::ROOT_W;
   localparam int RW = SW + 2;
   localparam int PW = 2 * SW;

   logic [PW-1:0] rad_ff  [SW];
   logic [RW-1:0] rem_ff  [SW];
   logic [SW-1:0] root_ff [SW];

   for (genvar k = 0; k < SW; k++) begin : gen_step
      logic [PW-1:0] rad_src;
      logic [RW-1:0] rem_src;
      logic [SW-1:0] root_src;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic [PW-1:0] rad_in;
      logic [RW-1:0] rem_in;
      logic [SW-1:0] root_in;

      if (k == 0) begin : gen_first
         assign rad_src  = PW'(rad);
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : gen_next
         assign rad_src  = rad_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src[RW-3:0], rad_src[PW-1 -: 2]};
         trial  = {root_src, 2'b01};
         rad_in = rad_src << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_src[SW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_src[SW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[SW-1];

endmodule

// ----- hw/rtl/qrro_div.sv -----
`timescale 1ns / 1ps

module qrro_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [qrro_pkg::NUMER_W-1:0] num,
   input  logic [qrro_pkg::DEN_W-1:0]   den,
   output logic [qrro_pkg::NUMER_W-1:0] quo
);

   localparam int NW = qrro_pkg::NUMER_W;
   localparam int DW = qrro_pkg::DEN_W;

   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] quo_ff [NW];

   for (genvar k = 0; k < NW; k++) begin : gen_step
      logic [NW-1:0] num_src;
      logic [DW-1:0] den_src;
      logic [DW-1:0] rem_src;
      logic [NW-1:0] quo_src;
      logic [DW:0]   rem_sh;
      logic [DW:0]   diff;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] quo_in;

      if (k == 0) begin : gen_first
         assign num_src = num;
         assign den_src = den;
         assign rem_src = '0;
         assign quo_src = '0;
      end else begin : gen_next
         assign num_src = num_ff[k-1];
         assign den_src = den_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src, num_src[NW-1]};
         diff   = rem_sh - {1'b0, den_src};
         if (rem_sh >= {1'b0, den_src}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_src[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DW-1:0];
            quo_in = {quo_src[NW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k] <= num_src << 1;
            den_ff[k] <= den_src;
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
         end
      end
   end

   assign quo = quo_ff[NW-1];

endmodule

// ----- hw/rtl/quadratic_real_roots_ordered.sv -----
`timescale 1ns / 1ps

// Ordered real roots of a*t^2 + b*t + c in signed Q16.16. The block takes one
// transaction per cycle unless the pipeline holds, and returns one result per
// transaction, in order, after register stages for magnitudes, products and the
// discriminant, the one-bit-per-stage square root, the numerators, the two
// one-bit-per-stage dividers and saturation into the output register.
// When rsp_ready is low with a result waiting, the whole pipeline holds.

module quadratic_real_roots_ordered (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qrro_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qrro_pkg::rsp_type rsp_data
);

   localparam int W   = qrro_pkg::WORD_BITS;
   localparam int DW  = qrro_pkg::DISC_W;
   localparam int SW  = qrro_pkg::ROOT_W;
   localparam int NMW = qrro_pkg::NUM_W;
   localparam int MW  = qrro_pkg::MAG_W;
   localparam int NW  = qrro_pkg::NUMER_W;
   localparam int DNW = qrro_pkg::DEN_W;

   function automatic logic [W:0] fix_root(input logic [NW-1:0] q, input logic neg);
      logic          over;
      logic [W-1:0]  val;
      if (!neg) begin
         over = (q[NW-1:W-1] != '0);
         val  = over ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
      end else begin
         over = (q[NW-1:W-1] != '0) && (q != (NW'(1) << (W-1)));
         val  = over ? {1'b1, {(W-1){1'b0}}} : W'(0) - q[W-1:0];
      end
      return {over, val};
   endfunction

   logic en;

   logic         s1_v_ff, s1_a_neg_ff, s1_a_zero_ff, s1_same_ff;
   logic [W-1:0] s1_a_mag_ff, s1_b_ff, s1_b_mag_ff, s1_c_mag_ff;
   logic [W-1:0] s1_a_mag_in, s1_b_mag_in, s1_c_mag_in;

   logic           s2_v_ff, s2_a_neg_ff, s2_a_zero_ff, s2_same_ff;
   logic [W-1:0]   s2_a_mag_ff, s2_b_ff;
   logic [2*W-1:0] s2_b2_ff, s2_ac_ff;

   logic                    s3_v_ff;
   logic [DW-1:0]           s3_d_ff;
   qrro_pkg::sqrt_side_type s3_side_ff;
   logic [DW:0]             s3_b2x, s3_ac4x, s3_diff, s3_sum;
   logic [DW-1:0]           s3_d_in;
   qrro_pkg::sqrt_side_type s3_side_in;

   logic                    sq_v_ff    [SW];
   qrro_pkg::sqrt_side_type sq_side_ff [SW];
   logic [SW-1:0]           sq_root;

   logic                        s4_v_ff, s4_lo_neg_ff, s4_hi_neg_ff;
   logic signed [NMW-1:0]       s4_lo_num_ff, s4_hi_num_ff;
   logic [W-1:0]                s4_a_mag_ff;
   qrro_pkg::status_type        s4_code_ff;
   logic signed [NMW-1:0]       s4_bx, s4_sx, s4_nm, s4_np, s4_lo_num_in, s4_hi_num_in;

   logic                   s5_v_ff;
   logic [NW-1:0]          s5_lo_ff, s5_hi_ff;
   logic [DNW-1:0]         s5_den_ff;
   qrro_pkg::div_side_type s5_side_ff;
   logic [NMW-1:0]         s5_lo_abs, s5_hi_abs;

   logic                   dv_v_ff    [NW];
   qrro_pkg::div_side_type dv_side_ff [NW];
   logic [NW-1:0]          lo_quo, hi_quo;

   logic              out_v_ff;
   qrro_pkg::rsp_type out_ff;
   qrro_pkg::rsp_type out_in;
   logic [W:0]        lo_fix, hi_fix;

   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      s1_a_mag_in = req_data.coef_sq[W-1]    ? W'(0) - W'(req_data.coef_sq)    : W'(req_data.coef_sq);
      s1_b_mag_in = req_data.coef_lin[W-1]   ? W'(0) - W'(req_data.coef_lin)   : W'(req_data.coef_lin);
      s1_c_mag_in = req_data.coef_const[W-1] ? W'(0) - W'(req_data.coef_const) : W'(req_data.coef_const);
   end

   always_comb begin
      s3_b2x  = (DW+1)'(s2_b2_ff);
      s3_ac4x = {s2_ac_ff, 2'b00};
      s3_diff = s3_b2x - s3_ac4x;
      s3_sum  = s3_b2x + s3_ac4x;
      s3_d_in = s2_same_ff ? s3_diff[DW-1:0] : s3_sum[DW-1:0];
      s3_side_in.a_neg = s2_a_neg_ff;
      s3_side_in.a_mag = s2_a_mag_ff;
      s3_side_in.b     = s2_b_ff;
      if (s2_a_zero_ff) begin
         s3_side_in.code = qrro_pkg::ST_ZERO_LEAD;
      end else if (s2_same_ff && s3_diff[DW]) begin
         s3_side_in.code = qrro_pkg::ST_NO_REAL;
      end else begin
         s3_side_in.code = qrro_pkg::ST_OK;
      end
   end

   qrro_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (s3_d_ff),
      .root  (sq_root)
   );

   always_comb begin
      s4_bx = signed'({{(NMW-W){sq_side_ff[SW-1].b[W-1]}}, sq_side_ff[SW-1].b});
      s4_sx = signed'({2'b00, sq_root});
      s4_nm = -s4_bx - s4_sx;
      s4_np = -s4_bx + s4_sx;
      s4_lo_num_in = sq_side_ff[SW-1].a_neg ? s4_np : s4_nm;
      s4_hi_num_in = sq_side_ff[SW-1].a_neg ? s4_nm : s4_np;
   end

   always_comb begin
      s5_lo_abs = s4_lo_num_ff[NMW-1] ? NMW'(0) - NMW'(s4_lo_num_ff) : NMW'(s4_lo_num_ff);
      s5_hi_abs = s4_hi_num_ff[NMW-1] ? NMW'(0) - NMW'(s4_hi_num_ff) : NMW'(s4_hi_num_ff);
   end

   qrro_div u_div_lo (
      .clock (clock),
      .en    (en),
      .num   (s5_lo_ff),
      .den   (s5_den_ff),
      .quo   (lo_quo)
   );

   qrro_div u_div_hi (
      .clock (clock),
      .en    (en),
      .num   (s5_hi_ff),
      .den   (s5_den_ff),
      .quo   (hi_quo)
   );

   always_comb begin
      lo_fix = fix_root(lo_quo, dv_side_ff[NW-1].lo_neg);
      hi_fix = fix_root(hi_quo, dv_side_ff[NW-1].hi_neg);
      if (dv_side_ff[NW-1].code == qrro_pkg::ST_OK) begin
         out_in.low_root  = lo_fix[W-1:0];
         out_in.high_root = hi_fix[W-1:0];
         out_in.status    = (lo_fix[W] || hi_fix[W]) ? qrro_pkg::ST_SAT : qrro_pkg::ST_OK;
      end else begin
         out_in.low_root  = qrro_pkg::MINUS_ONE;
         out_in.high_root = qrro_pkg::MINUS_ONE;
         out_in.status    = dv_side_ff[NW-1].code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k < SW; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k < NW; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         sq_v_ff[0] <= s3_v_ff;
         for (int k = 1; k < SW; k++) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
         s4_v_ff    <= sq_v_ff[SW-1];
         s5_v_ff    <= s4_v_ff;
         dv_v_ff[0] <= s5_v_ff;
         for (int k = 1; k < NW; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
         out_v_ff   <= dv_v_ff[NW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_a_neg_ff  <= req_data.coef_sq[W-1];
         s1_a_zero_ff <= (req_data.coef_sq == '0);
         s1_same_ff   <= (req_data.coef_const != '0)
                         && (req_data.coef_sq[W-1] == req_data.coef_const[W-1]);
         s1_a_mag_ff  <= s1_a_mag_in;
         s1_b_ff      <= W'(req_data.coef_lin);
         s1_b_mag_ff  <= s1_b_mag_in;
         s1_c_mag_ff  <= s1_c_mag_in;

         s2_a_neg_ff  <= s1_a_neg_ff;
         s2_a_zero_ff <= s1_a_zero_ff;
         s2_same_ff   <= s1_same_ff;
         s2_a_mag_ff  <= s1_a_mag_ff;
         s2_b_ff      <= s1_b_ff;
         s2_b2_ff     <= s1_b_mag_ff * s1_b_mag_ff;
         s2_ac_ff     <= s1_a_mag_ff * s1_c_mag_ff;

         s3_d_ff    <= s3_d_in;
         s3_side_ff <= s3_side_in;

         sq_side_ff[0] <= s3_side_ff;
         for (int k = 1; k < SW; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end

         s4_lo_num_ff <= s4_lo_num_in;
         s4_hi_num_ff <= s4_hi_num_in;
         s4_lo_neg_ff <= s4_lo_num_in[NMW-1] != sq_side_ff[SW-1].a_neg;
         s4_hi_neg_ff <= s4_hi_num_in[NMW-1] != sq_side_ff[SW-1].a_neg;
         s4_a_mag_ff  <= sq_side_ff[SW-1].a_mag;
         s4_code_ff   <= sq_side_ff[SW-1].code;

         s5_lo_ff          <= NW'(s5_lo_abs[MW-1:0]) << qrro_pkg::FRAC_BITS;
         s5_hi_ff          <= NW'(s5_hi_abs[MW-1:0]) << qrro_pkg::FRAC_BITS;
         s5_den_ff         <= {s4_a_mag_ff, 1'b0};
         s5_side_ff.lo_neg <= s4_lo_neg_ff;
         s5_side_ff.hi_neg <= s4_hi_neg_ff;
         s5_side_ff.code   <= s4_code_ff;

         dv_side_ff[0] <= s5_side_ff;
         for (int k = 1; k < NW; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end

         out_ff <= out_in;
      end
   end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY = 89;
   localparam longint CYCLE_LIMIT = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   qrro_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   qrro_pkg::rsp_type rsp_data;

   qrro_pkg::rsp_type roots_pending[$];
   int      error_count = 0;
   longint  cycle_count = 0;
   bit      idle_enable = 1'b0;
   bit      hold_request = 1'b0;
   bit      hold_done = 1'b0;

   quadratic_real_roots_ordered dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Unsigned magnitude of a signed value held in 128 bits.
   function automatic logic [127:0] magnitude(logic signed [127:0] v);
      return v < 0 ? -v : v;
   endfunction

   // Quotient num * 2^FRAC_BITS / (2a), truncated toward zero, saturated.
   function automatic logic [qrro_pkg::WORD_BITS-1:0] root_value(logic signed [127:0] num,
                                                                logic signed [127:0] a,
                                                                inout bit sat);
      logic [127:0] q;
      logic         neg;
      neg = (num < 0) != (a < 0);
      q = (magnitude(num) << qrro_pkg::FRAC_BITS) / (magnitude(a) << 1);
      if (!neg) begin
         if (q > ((128'(1) << (qrro_pkg::WORD_BITS - 1)) - 128'(1))) begin
            sat = 1'b1;
            return {1'b0, {(qrro_pkg::WORD_BITS - 1){1'b1}}};
         end
         return q[qrro_pkg::WORD_BITS-1:0];
      end
      if (q > (128'(1) << (qrro_pkg::WORD_BITS - 1))) begin
         sat = 1'b1;
         return {1'b1, {(qrro_pkg::WORD_BITS - 1){1'b0}}};
      end
      return qrro_pkg::WORD_BITS'(-q);
   endfunction

   function automatic logic [127:0] floor_sqrt(logic [127:0] d);
      logic [127:0] r;
      logic [127:0] cand;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = r | (128'(1) << i);
         if (cand * cand <= d) r = cand;
      end
      return r;
   endfunction

   function automatic qrro_pkg::rsp_type solve_roots(qrro_pkg::req_type q);
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] c;
      logic signed [127:0] disc;
      logic signed [127:0] s;
      qrro_pkg::rsp_type   r;
      bit                  sat;
      a = 128'(q.coef_sq);
      b = 128'(q.coef_lin);
      c = 128'(q.coef_const);
      sat = 1'b0;
      if (a == 0) begin
         r.low_root = qrro_pkg::MINUS_ONE;
         r.high_root = qrro_pkg::MINUS_ONE;
         r.status = qrro_pkg::ST_ZERO_LEAD;
         return r;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
         r.low_root = qrro_pkg::MINUS_ONE;
         r.high_root = qrro_pkg::MINUS_ONE;
         r.status = qrro_pkg::ST_NO_REAL;
         return r;
      end
      s = floor_sqrt(disc);
      if (a > 0) begin
         r.low_root = root_value(-b - s, a, sat);
         r.high_root = root_value(-b + s, a, sat);
      end else begin
         r.low_root = root_value(-b + s, a, sat);
         r.high_root = root_value(-b - s, a, sat);
      end
      r.status = sat ? qrro_pkg::ST_SAT : qrro_pkg::ST_OK;
      return r;
   endfunction

   task automatic send_coefficients(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      qrro_pkg::req_type q;
      q.coef_sq = a;
      q.coef_lin = b;
      q.coef_const = c;
      while (idle_enable && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      roots_pending.push_back(solve_roots(q));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (roots_pending.size() == 0) begin
            $error("unexpected transaction low_root=%h", rsp_data.low_root);
            error_count++;
         end else begin
            qrro_pkg::rsp_type e;
            e = roots_pending.pop_front();
            if (rsp_data.low_root !== e.low_root) begin
               $error("low_root expected %h actual %h", e.low_root, rsp_data.low_root);
               error_count++;
            end
            if (rsp_data.high_root !== e.high_root) begin
               $error("high_root expected %h actual %h", e.high_root, rsp_data.high_root);
               error_count++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            stall = 0;
            while (stall < 300) begin
               @(posedge clock);
               stall++;
            end
            hold_done = 1'b1;
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= !(idle_enable && $urandom_range(99) < 13);
         end
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(16'hffff)) - 32'sh8000);
         2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         3: return 32'($urandom_range(16) - 8) << 16;
         default: return 32'($signed($urandom_range(32'h1fffff)) - 32'sh100000);
      endcase
   endfunction

   task automatic test_extremes();
      logic [31:0] edges[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                32'h0001_0000, 32'hffff_0000, 32'h0000_0001};
      foreach (edges[i]) send_coefficients(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
      send_coefficients(32'h0, 32'h0001_0000, 32'h0002_0000);
      send_coefficients(32'h0001_0000, 32'h0, 32'h0001_0000);
      send_coefficients(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
      send_coefficients(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000);
      send_coefficients(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
      send_coefficients(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000);
      send_coefficients(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_coefficients(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_coefficients(32'h0000_0001, 32'h0, 32'h0);
   endtask

   task automatic test_back_pressure();
      hold_request = 1'b1;
      for (int i = 0; i < 150; i++) send_coefficients(random_word(), random_word(), random_word());
      req_valid <= 1'b0;
      while (!hold_done) @(posedge clock);
   endtask

   task automatic test_random(int count, bit with_idle);
      idle_enable = with_idle;
      for (int i = 0; i < count; i++) send_coefficients(random_word(), random_word(), random_word());
   endtask

   initial begin
      int waited;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random(200, 1'b0);
      test_back_pressure();
      test_random(750, 1'b1);
      req_valid <= 1'b0;
      waited = 0;
      while (roots_pending.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);
      if (roots_pending.size() != 0) begin
         $error("%0d expected transactions never arrived", roots_pending.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
